### rtl/core/stftm_pkg.sv
// Shared types, constants and table-building functions for the STFT magnitude block.
`default_nettype none
package stftm_pkg;

   // Configuration register indexes (byte address = 4 * index).
   localparam logic [1:0] REG_HOP_SIZE    = 2'd0;
   localparam logic [1:0] REG_WINDOW_KIND = 2'd1;
   localparam logic [1:0] REG_LOG_SCALE   = 2'd2;

   // Window selector codes.
   localparam logic [1:0] WIN_HANN      = 2'd0;
   localparam logic [1:0] WIN_BLACKMAN  = 2'd1;
   localparam logic [1:0] WIN_BLACK_HAR = 2'd2;

   localparam logic [8:0] HOP_SIZE_RESET = 9'd128;

   // Decibel scaling: 20*log10(2) in Q16 and the -120 dB floor in Q8.8.
   localparam logic signed [19:0] DB_PER_OCTAVE = 20'sd394566;
   localparam logic signed [19:0] DB_FLOOR      = -20'sd30720;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = 2;

   localparam longint ONE_Q30     = 64'sd1073741824;
   localparam longint HALF_PI_Q30 = 64'sd1686629713;

   typedef struct packed {
      logic signed [15:0] sample;
      logic               frame_due;
   } queue_entry_type;

   typedef struct packed {
      logic               last;
      logic [2:0]         bins_valid;
      logic signed [15:0] mag_d;
      logic signed [15:0] mag_c;
      logic signed [15:0] mag_b;
      logic signed [15:0] mag_a;
      logic [7:0]         first_bin;
   } result_type;

   // Cosine of f quarter turns (f in Q30, 0..1) by a Taylor series, Q30 result.
   function automatic longint cos_quarter(longint f);
      longint x;
      longint x2;
      longint t;
      x  = (f * HALF_PI_Q30) / ONE_Q30;
      x2 = (x * x) / ONE_Q30;
      t  = ONE_Q30;
      t  = ONE_Q30 - ((x2 * t) / ONE_Q30) / 182;
      t  = ONE_Q30 - ((x2 * t) / ONE_Q30) / 132;
      t  = ONE_Q30 - ((x2 * t) / ONE_Q30) / 90;
      t  = ONE_Q30 - ((x2 * t) / ONE_Q30) / 56;
      t  = ONE_Q30 - ((x2 * t) / ONE_Q30) / 30;
      t  = ONE_Q30 - ((x2 * t) / ONE_Q30) / 12;
      t  = ONE_Q30 - ((x2 * t) / ONE_Q30) / 2;
      return t;
   endfunction

   // Cosine of a phase in Q32 turns, Q30 result.
   function automatic longint cos_turn(logic [31:0] ph);
      longint f;
      longint r;
      f = longint'({34'd0, ph[29:0]});
      case (ph[31:30])
         2'd0: begin
            r = cos_quarter(f);
         end
         2'd1: begin
            r = -cos_quarter(ONE_Q30 - f);
         end
         2'd2: begin
            r = -cos_quarter(f);
         end
         default: begin
            r = cos_quarter(ONE_Q30 - f);
         end
      endcase
      return r;
   endfunction

   // Round a Q30 value to Q15, halves away from zero.
   function automatic logic signed [16:0] q15_of(longint x);
      longint m;
      longint r;
      m = (x < 0) ? -x : x;
      r = (m + 64'sd16384) >>> 15;
      return 17'((x < 0) ? -r : r);
   endfunction

   function automatic logic signed [16:0] hann_coef(longint c1);
      return q15_of((64'sd50000 * ONE_Q30 - 64'sd50000 * c1) / 64'sd100000);
   endfunction

   function automatic logic signed [16:0] blackman_coef(longint c1, longint c2);
      return q15_of((64'sd42000 * ONE_Q30 - 64'sd50000 * c1 + 64'sd8000 * c2) / 64'sd100000);
   endfunction

   function automatic logic signed [16:0] black_har_coef(longint c1, longint c2, longint c3);
      return q15_of((64'sd35875 * ONE_Q30 - 64'sd48829 * c1 + 64'sd14128 * c2
                     - 64'sd1168 * c3) / 64'sd100000);
   endfunction

endpackage
`default_nettype wire

### rtl/core/stftm_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module stftm_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

### rtl/core/stftm_queue.sv
// Short queue of classified samples between the front and back parts.
`default_nettype none
module stftm_queue (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      push,
   input  wire stftm_pkg::queue_entry_type push_data,
   output logic                           full,
   input  wire logic                      pop,
   output stftm_pkg::queue_entry_type     pop_data,
   output logic                           not_empty
);
   import stftm_pkg::*;

   queue_entry_type       slot_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_AW:0]     count_ff, count_in;

   assign full      = (count_ff == (QUEUE_AW+1)'(QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign pop_data  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff + QUEUE_AW'(push);
      rd_ptr_in = rd_ptr_ff + QUEUE_AW'(pop);
      count_in  = count_ff + (QUEUE_AW+1)'(push) - (QUEUE_AW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end
endmodule
`default_nettype wire

### rtl/core/stftm_front.sv
// Input side: accepts samples and marks the ones that complete a hop.
`default_nettype none
module stftm_front (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_tvalid,
   output logic                           req_tready,
   input  wire logic [15:0]               req_tdata,
   input  wire logic [8:0]                hop_size,
   output logic                           q_push,
   output stftm_pkg::queue_entry_type     q_data,
   input  wire logic                      q_full
);
   import stftm_pkg::*;

   logic [8:0] hop_count_ff, hop_count_in;
   logic [9:0] count_next;
   logic       due;

   assign req_tready = !q_full;
   assign q_push     = req_tvalid && !q_full;

   always_comb begin
      count_next     = {1'b0, hop_count_ff} + 10'd1;
      due            = (count_next >= {1'b0, hop_size});
      q_data.sample    = $signed(req_tdata);
      q_data.frame_due = due;
      hop_count_in   = hop_count_ff;
      if (q_push) begin
         hop_count_in = due ? 9'd0 : count_next[8:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hop_count_ff <= '0;
      end else begin
         hop_count_ff <= hop_count_in;
      end
   end
endmodule
`default_nettype wire

### rtl/core/stftm_mag.sv
// Bin magnitude unit: rounding, squares, bit-serial square root, log or linear scaling.
`default_nettype none
module stftm_mag #(
   parameter int LOG_N = 8,
   parameter int ACC_W = 56
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    start,
   input  wire logic signed [ACC_W-1:0] acc_re,
   input  wire logic signed [ACC_W-1:0] acc_im,
   input  wire logic                    log_scale,
   output logic                         done,
   output logic signed [15:0]           mag
);
   import stftm_pkg::*;

   localparam int RS_W = ACC_W - 24;
   localparam logic [ACC_W-1:0] HalfLsb = ACC_W'(1) << 23;
   localparam logic [32:0] LinBias = 33'(16) << LOG_N;
   localparam logic [22:0] LogOff = 23'((LOG_N + 20) * 65536);

   typedef enum logic [9:0] {
      M_IDLE  = 10'b0000000001,
      M_SQRE  = 10'b0000000010,
      M_SQIM  = 10'b0000000100,
      M_ROOT  = 10'b0000001000,
      M_PICK  = 10'b0000010000,
      M_NORM  = 10'b0000100000,
      M_LMUL  = 10'b0001000000,
      M_LNRM  = 10'b0010000000,
      M_SCALE = 10'b0100000000,
      M_FIN   = 10'b1000000000
   } mag_state_type;

   mag_state_type        state_ff, state_in;
   logic [RS_W-1:0]      re_ff, re_in, im_ff, im_in;
   logic [63:0]          pow_ff, pow_in;
   logic [63:0]          r_ff, r_in, bit_ff, bit_in;
   logic [31:0]          y_ff, y_in;
   logic [4:0]           e_ff, e_in;
   logic [30:0]          yq_ff, yq_in;
   logic [61:0]          sqp_ff, sqp_in;
   logic [15:0]          frac_ff, frac_in;
   logic [3:0]           it_ff, it_in;
   logic signed [42:0]   prod_ff, prod_in;
   logic                 done_ff, done_in;
   logic signed [15:0]   mag_ff, mag_in;

   logic [ACC_W-1:0]     re_abs, im_abs, re_rnd, im_rnd;
   logic [RS_W-1:0]      sq_op;
   logic [2*RS_W-1:0]    sq;
   logic [63:0]          trial;
   logic [32:0]          lin_sum, lin_q;
   logic [31:0]          root, t_sq;
   logic signed [22:0]   lval;
   logic [42:0]          p_abs, p_rnd;
   logic signed [19:0]   db;

   assign done = done_ff;
   assign mag  = mag_ff;

   always_comb begin
      state_in = state_ff;
      re_in    = re_ff;
      im_in    = im_ff;
      pow_in   = pow_ff;
      r_in     = r_ff;
      bit_in   = bit_ff;
      y_in     = y_ff;
      e_in     = e_ff;
      yq_in    = yq_ff;
      sqp_in   = sqp_ff;
      frac_in  = frac_ff;
      it_in    = it_ff;
      prod_in  = prod_ff;
      done_in  = 1'b0;
      mag_in   = mag_ff;

      re_abs = acc_re[ACC_W-1] ? ACC_W'(-acc_re) : ACC_W'(acc_re);
      im_abs = acc_im[ACC_W-1] ? ACC_W'(-acc_im) : ACC_W'(acc_im);
      re_rnd = re_abs + HalfLsb;
      im_rnd = im_abs + HalfLsb;

      sq_op   = (state_ff == M_SQRE) ? re_ff : im_ff;
      sq      = sq_op * sq_op;
      trial   = r_ff + bit_ff;
      root    = r_ff[31:0];
      lin_sum = {1'b0, root} + LinBias;
      lin_q   = lin_sum >> (5 + LOG_N);
      t_sq    = sqp_ff[61:30];
      lval    = $signed(23'({2'b00, e_ff, frac_ff}) - LogOff);
      p_abs   = prod_ff[42] ? 43'(-prod_ff) : 43'(prod_ff);
      p_rnd   = p_abs + 43'(24'h80_0000);
      db      = prod_ff[42] ? -$signed(20'({1'b0, p_rnd[42:24]}))
                            : $signed(20'({1'b0, p_rnd[42:24]}));

      case (state_ff)
         M_IDLE: begin
            if (start) begin
               re_in    = re_rnd[ACC_W-1:24];
               im_in    = im_rnd[ACC_W-1:24];
               state_in = M_SQRE;
            end
         end
         M_SQRE: begin
            pow_in   = 64'(sq);
            state_in = M_SQIM;
         end
         M_SQIM: begin
            pow_in   = pow_ff + 64'(sq);
            r_in     = '0;
            bit_in   = 64'd1 << 62;
            state_in = M_ROOT;
         end
         M_ROOT: begin
            if (bit_ff == '0) begin
               state_in = M_PICK;
            end else begin
               if (pow_ff >= trial) begin
                  pow_in = pow_ff - trial;
                  r_in   = (r_ff >> 1) + bit_ff;
               end else begin
                  r_in = r_ff >> 1;
               end
               bit_in = bit_ff >> 2;
            end
         end
         M_PICK: begin
            if (!log_scale) begin
               mag_in   = (lin_q > 33'd32767) ? 16'sd32767 : $signed(lin_q[15:0]);
               done_in  = 1'b1;
               state_in = M_IDLE;
            end else if (root == '0) begin
               mag_in   = 16'(DB_FLOOR);
               done_in  = 1'b1;
               state_in = M_IDLE;
            end else begin
               y_in     = root;
               e_in     = 5'd31;
               state_in = M_NORM;
            end
         end
         M_NORM: begin
            if (y_ff[31]) begin
               yq_in    = y_ff[31:1];
               frac_in  = '0;
               it_in    = '0;
               state_in = M_LMUL;
            end else begin
               y_in = y_ff << 1;
               e_in = e_ff - 5'd1;
            end
         end
         M_LMUL: begin
            sqp_in   = yq_ff * yq_ff;
            state_in = M_LNRM;
         end
         M_LNRM: begin
            if (t_sq[31]) begin
               yq_in   = t_sq[31:1];
               frac_in = {frac_ff[14:0], 1'b1};
            end else begin
               yq_in   = t_sq[30:0];
               frac_in = {frac_ff[14:0], 1'b0};
            end
            it_in    = it_ff + 4'd1;
            state_in = (it_ff == 4'd15) ? M_SCALE : M_LMUL;
         end
         M_SCALE: begin
            prod_in  = lval * DB_PER_OCTAVE;
            state_in = M_FIN;
         end
         M_FIN: begin
            if (db > 20'sd0) begin
               mag_in = '0;
            end else if (db < DB_FLOOR) begin
               mag_in = 16'(DB_FLOOR);
            end else begin
               mag_in = 16'(db);
            end
            done_in  = 1'b1;
            state_in = M_IDLE;
         end
         default: begin
            state_in = M_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= M_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      re_ff   <= re_in;
      im_ff   <= im_in;
      pow_ff  <= pow_in;
      r_ff    <= r_in;
      bit_ff  <= bit_in;
      y_ff    <= y_in;
      e_ff    <= e_in;
      yq_ff   <= yq_in;
      sqp_ff  <= sqp_in;
      frac_ff <= frac_in;
      it_ff   <= it_in;
      prod_ff <= prod_in;
      mag_ff  <= mag_in;
   end
endmodule
`default_nettype wire

### rtl/core/stftm_back.sv
// Back part: sample ring, mean, window, DFT sequencer, result packing.
`default_nettype none
module stftm_back #(
   parameter int FFT_SIZE = 256
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      q_valid,
   input  wire stftm_pkg::queue_entry_type q_data,
   output logic                           q_pop,
   input  wire logic [1:0]                window_kind,
   input  wire logic                      log_scale,
   input  wire logic                      rsp_ready,
   output logic                           rsp_valid,
   output stftm_pkg::result_type          rsp_word
);
   import stftm_pkg::*;

   localparam int LOG_N  = $clog2(FFT_SIZE);
   localparam int CW     = LOG_N + 1;
   localparam int ACC_W  = 48 + LOG_N;
   localparam int SW     = 16 + LOG_N;
   localparam int WinPer = FFT_SIZE - 1;
   localparam logic [LOG_N-1:0] LastBin = LOG_N'(FFT_SIZE / 2);

   typedef enum logic [5:0] {
      ST_IDLE = 6'b000001,
      ST_MEAN = 6'b000010,
      ST_WIN  = 6'b000100,
      ST_BIN  = 6'b001000,
      ST_MAG  = 6'b010000,
      ST_EMIT = 6'b100000
   } back_state_type;

   logic signed [16:0] cos_rom   [FFT_SIZE];
   logic signed [16:0] sin_rom   [FFT_SIZE];
   logic signed [16:0] hann_rom  [FFT_SIZE];
   logic signed [16:0] black_rom [FFT_SIZE];
   logic signed [16:0] bh_rom    [FFT_SIZE];

   for (genvar g = 0; g < FFT_SIZE; g++) begin : g_tab
      localparam logic [31:0] PhT = 32'(64'(g) << (32 - LOG_N));
      localparam logic [31:0] Ph1 = 32'((64'(g % WinPer) << 32) / WinPer);
      localparam logic [31:0] Ph2 = 32'((64'((2 * g) % WinPer) << 32) / WinPer);
      localparam logic [31:0] Ph3 = 32'((64'((3 * g) % WinPer) << 32) / WinPer);
      assign cos_rom[g]   = q15_of(cos_turn(PhT));
      assign sin_rom[g]   = q15_of(cos_turn(PhT - 32'h4000_0000));
      assign hann_rom[g]  = hann_coef(cos_turn(Ph1));
      assign black_rom[g] = blackman_coef(cos_turn(Ph1), cos_turn(Ph2));
      assign bh_rom[g]    = black_har_coef(cos_turn(Ph1), cos_turn(Ph2), cos_turn(Ph3));
   end

   back_state_type          state_ff, state_in;
   logic [LOG_N-1:0]        wp_ff, wp_in;
   logic [CW-1:0]           fill_ff, fill_in;
   logic [CW-1:0]           cnt_ff, cnt_in;
   logic [LOG_N-1:0]        k_ff, k_in;
   logic [LOG_N-1:0]        tw_ff, tw_in;
   logic                    s1_v_ff, s1_v_in, s1_ok_ff, s1_ok_in;
   logic [LOG_N-1:0]        s1_idx_ff, s1_idx_in;
   logic                    s2_v_ff, s2_v_in, s3_v_ff, s3_v_in;
   logic signed [SW-1:0]    sum_ff, sum_in;
   logic signed [15:0]      mean_ff, mean_in;
   logic signed [31:0]      wq_ff, wq_in;
   logic signed [16:0]      cq_ff, cq_in, sq_ff, sq_in;
   logic signed [47:0]      pre_ff, pre_in, pim_ff, pim_in;
   logic signed [ACC_W-1:0] acc_re_ff, acc_re_in, acc_im_ff, acc_im_in;
   logic signed [15:0]      mags_ff [4];
   logic signed [15:0]      mags_in [4];
   logic                    rsp_valid_ff, rsp_valid_in;
   result_type              rsp_word_ff, rsp_word_in;

   logic [LOG_N-1:0]        ring_addr;
   logic [15:0]             ring_q;
   logic [31:0]             work_q;
   logic signed [31:0]      work_in;
   logic                    work_wr;
   logic                    issue, sweep_done, out_free, mag_start, mag_done;
   logic signed [15:0]      mag_val, samp;
   logic signed [SW-1:0]    sum_rnd;
   logic signed [16:0]      diff, win_val;

   stftm_ram #(.WIDTH(16), .DEPTH(FFT_SIZE)) u_ring (
      .clock   (clock),
      .wr_en   (q_pop),
      .wr_addr (wp_ff),
      .wr_data (q_data.sample),
      .rd_addr (ring_addr),
      .rd_data (ring_q)
   );

   stftm_ram #(.WIDTH(32), .DEPTH(FFT_SIZE)) u_work (
      .clock   (clock),
      .wr_en   (work_wr),
      .wr_addr (s1_idx_ff),
      .wr_data (work_in),
      .rd_addr (cnt_ff[LOG_N-1:0]),
      .rd_data (work_q)
   );

   stftm_mag #(.LOG_N(LOG_N), .ACC_W(ACC_W)) u_mag (
      .clock     (clock),
      .reset     (reset),
      .start     (mag_start),
      .acc_re    (acc_re_ff),
      .acc_im    (acc_im_ff),
      .log_scale (log_scale),
      .done      (mag_done),
      .mag       (mag_val)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   always_comb begin
      case (window_kind)
         WIN_BLACKMAN:  win_val = black_rom[s1_idx_ff];
         WIN_BLACK_HAR: win_val = bh_rom[s1_idx_ff];
         default:       win_val = hann_rom[s1_idx_ff];
      endcase
   end

   always_comb begin
      state_in  = state_ff;
      wp_in     = wp_ff;
      fill_in   = fill_ff;
      cnt_in    = cnt_ff;
      k_in      = k_ff;
      tw_in     = tw_ff;
      sum_in    = sum_ff;
      mean_in   = mean_ff;
      acc_re_in = acc_re_ff;
      acc_im_in = acc_im_ff;
      mags_in   = mags_ff;
      rsp_word_in  = rsp_word_ff;
      out_free     = !rsp_valid_ff || rsp_ready;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      q_pop     = 1'b0;
      mag_start = 1'b0;

      ring_addr  = wp_ff + cnt_ff[LOG_N-1:0];
      issue      = (state_ff == ST_MEAN || state_ff == ST_WIN || state_ff == ST_BIN)
                   && !cnt_ff[LOG_N];
      sweep_done = cnt_ff[LOG_N] && !s1_v_ff && !s2_v_ff && !s3_v_ff;

      s1_v_in   = issue;
      s1_ok_in  = ({1'b0, ring_addr} < fill_ff);
      s1_idx_in = (state_ff == ST_BIN) ? tw_ff : cnt_ff[LOG_N-1:0];
      if (issue) begin
         cnt_in = cnt_ff + CW'(1);
         tw_in  = tw_ff + k_ff;
      end

      samp    = s1_ok_ff ? $signed(ring_q) : 16'sd0;
      diff    = 17'(samp) - 17'(mean_ff);
      work_in = 32'(diff * win_val);
      work_wr = (state_ff == ST_WIN) && s1_v_ff;
      sum_rnd = sum_ff + SW'(FFT_SIZE / 2);

      s2_v_in = s1_v_ff && (state_ff == ST_BIN);
      wq_in   = $signed(work_q);
      cq_in   = cos_rom[s1_idx_ff];
      sq_in   = sin_rom[s1_idx_ff];
      s3_v_in = s2_v_ff;
      pre_in  = wq_ff * cq_ff;
      pim_in  = wq_ff * sq_ff;

      case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               q_pop = 1'b1;
               wp_in = wp_ff + LOG_N'(1);
               if (!fill_ff[LOG_N]) begin
                  fill_in = fill_ff + CW'(1);
               end
               if (q_data.frame_due) begin
                  cnt_in   = '0;
                  sum_in   = '0;
                  k_in     = '0;
                  for (int j = 0; j < 4; j++) begin
                     mags_in[j] = '0;
                  end
                  state_in = ST_MEAN;
               end
            end
         end
         ST_MEAN: begin
            if (s1_v_ff) begin
               sum_in = sum_ff + SW'(samp);
            end
            if (sweep_done) begin
               mean_in  = 16'(sum_rnd >>> LOG_N);
               cnt_in   = '0;
               state_in = ST_WIN;
            end
         end
         ST_WIN: begin
            if (sweep_done) begin
               cnt_in    = '0;
               tw_in     = '0;
               acc_re_in = '0;
               acc_im_in = '0;
               state_in  = ST_BIN;
            end
         end
         ST_BIN: begin
            if (s3_v_ff) begin
               acc_re_in = acc_re_ff + ACC_W'(pre_ff);
               acc_im_in = acc_im_ff + ACC_W'(pim_ff);
            end
            if (sweep_done) begin
               mag_start = 1'b1;
               state_in  = ST_MAG;
            end
         end
         ST_MAG: begin
            if (mag_done) begin
               mags_in[k_ff[1:0]] = mag_val;
               if (k_ff[1:0] == 2'd3 || k_ff == LastBin) begin
                  state_in = ST_EMIT;
               end else begin
                  k_in      = k_ff + LOG_N'(1);
                  cnt_in    = '0;
                  tw_in     = '0;
                  acc_re_in = '0;
                  acc_im_in = '0;
                  state_in  = ST_BIN;
               end
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in           = 1'b1;
               rsp_word_in.first_bin  = 8'({k_ff[LOG_N-1:2], 2'b00});
               rsp_word_in.mag_a      = mags_ff[0];
               rsp_word_in.mag_b      = mags_ff[1];
               rsp_word_in.mag_c      = mags_ff[2];
               rsp_word_in.mag_d      = mags_ff[3];
               rsp_word_in.bins_valid = 3'(k_ff[1:0]) + 3'd1;
               rsp_word_in.last       = (k_ff == LastBin);
               for (int j = 0; j < 4; j++) begin
                  mags_in[j] = '0;
               end
               if (k_ff == LastBin) begin
                  state_in = ST_IDLE;
               end else begin
                  k_in      = k_ff + LOG_N'(1);
                  cnt_in    = '0;
                  tw_in     = '0;
                  acc_re_in = '0;
                  acc_im_in = '0;
                  state_in  = ST_BIN;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         wp_ff        <= '0;
         fill_ff      <= '0;
         cnt_ff       <= '0;
         s1_v_ff      <= 1'b0;
         s2_v_ff      <= 1'b0;
         s3_v_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wp_ff        <= wp_in;
         fill_ff      <= fill_in;
         cnt_ff       <= cnt_in;
         s1_v_ff      <= s1_v_in;
         s2_v_ff      <= s2_v_in;
         s3_v_ff      <= s3_v_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      k_ff        <= k_in;
      tw_ff       <= tw_in;
      s1_ok_ff    <= s1_ok_in;
      s1_idx_ff   <= s1_idx_in;
      sum_ff      <= sum_in;
      mean_ff     <= mean_in;
      wq_ff       <= wq_in;
      cq_ff       <= cq_in;
      sq_ff       <= sq_in;
      pre_ff      <= pre_in;
      pim_ff      <= pim_in;
      acc_re_ff   <= acc_re_in;
      acc_im_ff   <= acc_im_in;
      mags_ff     <= mags_in;
      rsp_word_ff <= rsp_word_in;
   end
endmodule
`default_nettype wire

### rtl/core/stft_magnitude_frames.sv
// Frame sequence: a sample that completes a hop starts its frame once the back part is free;
// the frame runs a mean sweep and a window sweep over N samples, then (N/2+1) bins, each
// with a DFT sweep and a pass through the shared magnitude unit.
// Throughput: the idle back part takes one sample that completes no hop per cycle; the
// DFT multiply-accumulate sweep over one product pair per cycle sets the frame time.
// Reset is synchronous and active high: the frame reads as zeros, registers take defaults.
`default_nettype none
module stft_magnitude_frames #(
   parameter int FFT_SIZE = 256
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // Input samples.
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [15:0] req_tdata,   // [15:0] sample
   // Result words, up to four bins each.
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [79:0]      rsp_tdata,   // [7:0] first_bin, [23:8] mag_a, [39:24] mag_b,
                                         // [55:40] mag_c, [71:56] mag_d, [74:72] bins_valid
   output logic             rsp_tlast,
   // Configuration port.
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [3:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);
   import stftm_pkg::*;

   // Configuration registers. Writes land on the access cycle of the bus transfer.
   logic [8:0] hop_size_ff, hop_size_in;
   logic [1:0] window_kind_ff, window_kind_in;
   logic       log_scale_ff, log_scale_in;
   logic       csr_write;

   queue_entry_type q_in_data, q_out_data;
   logic            q_push, q_full, q_pop, q_valid;
   result_type      rsp_word;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      hop_size_in    = hop_size_ff;
      window_kind_in = window_kind_ff;
      log_scale_in   = log_scale_ff;
      if (csr_write) begin
         case (csr_paddr[3:2])
            REG_HOP_SIZE:    hop_size_in    = csr_pwdata[8:0];
            REG_WINDOW_KIND: window_kind_in = csr_pwdata[1:0];
            REG_LOG_SCALE:   log_scale_in   = csr_pwdata[0];
            default:         hop_size_in    = hop_size_ff;
         endcase
      end
      case (csr_paddr[3:2])
         REG_HOP_SIZE:    csr_prdata = 32'(hop_size_ff);
         REG_WINDOW_KIND: csr_prdata = 32'(window_kind_ff);
         REG_LOG_SCALE:   csr_prdata = 32'(log_scale_ff);
         default:         csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hop_size_ff    <= HOP_SIZE_RESET;
         window_kind_ff <= WIN_HANN;
         log_scale_ff   <= 1'b1;
      end else begin
         hop_size_ff    <= hop_size_in;
         window_kind_ff <= window_kind_in;
         log_scale_ff   <= log_scale_in;
      end
   end

   // The front part counts the hop and tags each sample; the queue lets it keep
   // taking samples while the back part is busy with a frame, until the queue is full.
   stftm_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .hop_size   (hop_size_ff),
      .q_push     (q_push),
      .q_data     (q_in_data),
      .q_full     (q_full)
   );

   stftm_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_in_data),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (q_out_data),
      .not_empty (q_valid)
   );

   // The back part stores each sample in the frame ring and runs the transform
   // when a tagged sample arrives. Its output register holds one result word.
   stftm_back #(.FFT_SIZE(FFT_SIZE)) u_back (
      .clock       (clock),
      .reset       (reset),
      .q_valid     (q_valid),
      .q_data      (q_out_data),
      .q_pop       (q_pop),
      .window_kind (window_kind_ff),
      .log_scale   (log_scale_ff),
      .rsp_ready   (rsp_tready),
      .rsp_valid   (rsp_tvalid),
      .rsp_word    (rsp_word)
   );

   assign rsp_tdata = {5'd0, rsp_word.bins_valid, rsp_word.mag_d, rsp_word.mag_c,
                       rsp_word.mag_b, rsp_word.mag_a, rsp_word.first_bin};
   assign rsp_tlast = rsp_word.last;
endmodule
`default_nettype wire
